// ----- hdl/cpau_pkg.sv -----
package cpau_pkg;

    localparam int FRAC_BITS = 8;
    localparam int HALF      = (FRAC_BITS > 0) ? (1 << ((FRAC_BITS > 0) ? FRAC_BITS - 1 : 0)) : 0;
    // Width of the divider remainder and of the shifted divisor.
    localparam int WN        = 52;
    // Quotient bits kept before saturation; one divider stage per bit.
    localparam int QB        = 17;

    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_SUB   = 3'd1,
        OP_EQUAL = 3'd2,
        OP_CMUL  = 3'd3,
        OP_CDIV  = 3'd4,
        OP_EMUL  = 3'd5,
        OP_SCALE = 3'd6,
        OP_BAD   = 3'd7
    } opcode_t;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [15:0] a_first;
        logic signed [15:0] a_second;
        logic signed [15:0] b_first;
        logic signed [15:0] b_second;
    } operands_t;

    typedef struct packed {
        logic signed [15:0] r_first;
        logic signed [15:0] r_second;
        logic               is_equal;
        logic               error_flag;
    } result_t;

    // Side information that travels alongside the divider stages.
    typedef struct packed {
        logic signed [15:0] r0;
        logic signed [15:0] r1;
        logic               eq;
        logic               err;
        logic               is_div;
        logic               zero;
        logic               neg0;
        logic               neg1;
        logic               ovf0;
        logic               ovf1;
    } pass_t;

    // Saturate to 16 bits; bit 16 of the return value is the error flag.
    function automatic logic [16:0] sat16(input logic signed [33:0] x);
        logic [16:0] r;
        if (x > 34'sd32767) begin
            r = {1'b1, 16'h7fff};
        end else if (x < -34'sd32768) begin
            r = {1'b1, 16'h8000};
        end else begin
            r = {1'b0, x[15:0]};
        end
        return r;
    endfunction

    // Round to nearest, ties toward plus infinity, then saturate.
    function automatic logic [16:0] rescale_sat(input logic signed [33:0] x);
        logic signed [33:0] t;
        t = (x + 34'(HALF)) >>> FRAC_BITS;
        return sat16(t);
    endfunction

    // Apply the sign to a quotient magnitude and saturate.
    function automatic logic [16:0] qsat(input logic [QB-1:0] q, input logic neg,
                                         input logic ovf);
        logic [16:0] r;
        if (neg) begin
            if (ovf || q > QB'(32768)) begin
                r = {1'b1, 16'h8000};
            end else begin
                r = {1'b0, 16'(-q)};
            end
        end else begin
            if (ovf || q > QB'(32767)) begin
                r = {1'b1, 16'h7fff};
            end else begin
                r = {1'b0, q[15:0]};
            end
        end
        return r;
    endfunction

endpackage

// ----- hdl/complex_and_pair_arithmetic_unit.sv -----
// Pipelined arithmetic unit for pairs of signed fixed-point numbers.
// An item is a transfer on the command port: operands with the opcode are
// taken at a rising edge where start is high and busy is low. busy stays
// low, so a new item can be issued in every cycle.
// Each item gives one result. It appears on result for exactly one cycle,
// marked by done, and results come out in issue order. Throughput is one
// item per cycle.
// The latency is set by the complex divider: two restoring dividers, one
// for each component, each producing one quotient bit per pipeline stage
// over 17 stages. All other operations take the same path so that results
// stay in order.
// Stages: input register, six 16x16 multipliers, sums and rounding,
// divider setup, 17 divider stages, output register.
// Reset clears every valid bit, so nothing is reported after reset until a
// new item arrives. The receiver cannot stall, so no result is ever held.
module complex_and_pair_arithmetic_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  cpau_pkg::operands_t operands,
    output logic                done,
    output cpau_pkg::result_t   result
);
    import cpau_pkg::*;

    logic      v1_reg;
    operands_t in_reg;

    logic               v2_reg;
    logic [2:0]         op2_reg;
    logic signed [31:0] p_arbr_reg, p_aibi_reg, p_aibr_reg, p_arbi_reg;
    logic signed [31:0] p_brbr_reg, p_bibi_reg;
    logic [16:0]        as0_reg, as1_reg;
    logic               eq2_reg;

    logic               v3_reg;
    pass_t              pass3_reg;
    logic signed [32:0] num0_reg, num1_reg;
    logic [32:0]        den_reg;

    logic          dv_reg   [0:QB];
    pass_t         pass_reg [0:QB];
    logic [WN-1:0] rem0_reg [0:QB];
    logic [WN-1:0] rem1_reg [0:QB];
    logic [WN-1:0] dd_reg   [0:QB];
    logic [QB-1:0] q0_reg   [0:QB];
    logic [QB-1:0] q1_reg   [0:QB];

    logic    done_reg;
    result_t result_reg;

    assign busy   = 1'b0;
    assign done   = done_reg;
    assign result = result_reg;

    // Stage 1: operand register.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
        end else begin
            v1_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk) begin
        if (start && !busy) begin
            in_reg <= operands;
        end
    end

    // Stage 2: products, add and subtract, compare.
    logic [16:0] as0_next, as1_next;
    always_comb begin
        unique case (opcode_t'(in_reg.opcode))
            OP_SUB: begin
                as0_next = sat16(34'(in_reg.a_first) - 34'(in_reg.b_first));
                as1_next = sat16(34'(in_reg.a_second) - 34'(in_reg.b_second));
            end
            default: begin
                as0_next = sat16(34'(in_reg.a_first) + 34'(in_reg.b_first));
                as1_next = sat16(34'(in_reg.a_second) + 34'(in_reg.b_second));
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v2_reg <= 1'b0;
        end else begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk) begin
        op2_reg    <= in_reg.opcode;
        p_arbr_reg <= in_reg.a_first * in_reg.b_first;
        p_aibi_reg <= in_reg.a_second * in_reg.b_second;
        p_aibr_reg <= in_reg.a_second * in_reg.b_first;
        p_arbi_reg <= in_reg.a_first * in_reg.b_second;
        p_brbr_reg <= in_reg.b_first * in_reg.b_first;
        p_bibi_reg <= in_reg.b_second * in_reg.b_second;
        as0_reg    <= as0_next;
        as1_reg    <= as1_next;
        eq2_reg    <= (in_reg.a_first == in_reg.b_first)
                   && (in_reg.a_second == in_reg.b_second);
    end

    // Stage 3: sums of products; rounding and saturation for the multiplying operations.
    pass_t              pass3_next;
    logic signed [32:0] num0_next, num1_next;
    logic [16:0]        x0, x1;
    always_comb begin
        num0_next = 33'(p_arbr_reg) + 33'(p_aibi_reg);
        num1_next = 33'(p_aibr_reg) - 33'(p_arbi_reg);
        x0 = 17'd0;
        x1 = 17'd0;
        pass3_next = '0;
        unique case (opcode_t'(op2_reg))
            OP_ADD, OP_SUB: begin
                x0 = as0_reg;
                x1 = as1_reg;
            end
            OP_EQUAL: pass3_next.eq = eq2_reg;
            OP_CMUL: begin
                x0 = rescale_sat(34'(p_arbr_reg) - 34'(p_aibi_reg));
                x1 = rescale_sat(34'(p_aibr_reg) + 34'(p_arbi_reg));
            end
            OP_CDIV: pass3_next.is_div = 1'b1;
            OP_EMUL: begin
                x0 = rescale_sat(34'(p_arbr_reg));
                x1 = rescale_sat(34'(p_aibi_reg));
            end
            OP_SCALE: begin
                x0 = rescale_sat(34'(p_arbr_reg));
                x1 = rescale_sat(34'(p_aibr_reg));
            end
            OP_BAD: pass3_next.err = 1'b1;
        endcase
        pass3_next.r0 = x0[15:0];
        pass3_next.r1 = x1[15:0];
        if (x0[16] || x1[16]) begin
            pass3_next.err = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v3_reg <= 1'b0;
        end else begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk) begin
        pass3_reg <= pass3_next;
        num0_reg  <= num0_next;
        num1_reg  <= num1_next;
        den_reg   <= 33'($unsigned(p_brbr_reg)) + 33'($unsigned(p_bibi_reg));
    end

    // Stage 4: divider setup. The rounded quotient is floor((2*mag*2^FRAC_BITS + d) / (2*d)).
    logic [32:0]   mag0, mag1;
    logic [WN-1:0] n0, n1, dd0;
    pass_t         pass4_next;
    always_comb begin
        mag0 = num0_reg[32] ? 33'(-num0_reg) : 33'(num0_reg);
        mag1 = num1_reg[32] ? 33'(-num1_reg) : 33'(num1_reg);
        dd0  = WN'(den_reg) << 1;
        n0   = ((WN'(mag0) << FRAC_BITS) << 1) + WN'(den_reg);
        n1   = ((WN'(mag1) << FRAC_BITS) << 1) + WN'(den_reg);
        pass4_next      = pass3_reg;
        pass4_next.zero = (den_reg == '0);
        pass4_next.neg0 = num0_reg[32];
        pass4_next.neg1 = num1_reg[32];
        // A quotient of more than QB bits saturates anyway.
        pass4_next.ovf0 = n0 >= (dd0 << QB);
        pass4_next.ovf1 = n1 >= (dd0 << QB);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            dv_reg[0] <= 1'b0;
        end else begin
            dv_reg[0] <= v3_reg;
        end
    end

    always_ff @(posedge clk) begin
        pass_reg[0] <= pass4_next;
        rem0_reg[0] <= n0;
        rem1_reg[0] <= n1;
        dd_reg[0]   <= dd0;
        q0_reg[0]   <= '0;
        q1_reg[0]   <= '0;
    end

    // Divider stages: stage j settles quotient bit QB-j of both components.
    logic [WN-1:0] rem0_next [1:QB];
    logic [WN-1:0] rem1_next [1:QB];
    logic [QB-1:0] q0_next   [1:QB];
    logic [QB-1:0] q1_next   [1:QB];
    logic [WN-1:0] trial     [1:QB];
    always_comb begin
        for (int j = 1; j <= QB; j++) begin
            trial[j]     = dd_reg[j-1] << (QB - j);
            rem0_next[j] = rem0_reg[j-1];
            rem1_next[j] = rem1_reg[j-1];
            q0_next[j]   = q0_reg[j-1];
            q1_next[j]   = q1_reg[j-1];
            if (rem0_reg[j-1] >= trial[j]) begin
                rem0_next[j]        = rem0_reg[j-1] - trial[j];
                q0_next[j][QB - j] = 1'b1;
            end
            if (rem1_reg[j-1] >= trial[j]) begin
                rem1_next[j]        = rem1_reg[j-1] - trial[j];
                q1_next[j][QB - j] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int j = 1; j <= QB; j++) begin
                dv_reg[j] <= 1'b0;
            end
        end else begin
            for (int j = 1; j <= QB; j++) begin
                dv_reg[j] <= dv_reg[j-1];
            end
        end
    end

    always_ff @(posedge clk) begin
        for (int j = 1; j <= QB; j++) begin
            pass_reg[j] <= pass_reg[j-1];
            rem0_reg[j] <= rem0_next[j];
            rem1_reg[j] <= rem1_next[j];
            dd_reg[j]   <= dd_reg[j-1];
            q0_reg[j]   <= q0_next[j];
            q1_reg[j]   <= q1_next[j];
        end
    end

    // Output stage.
    result_t     result_next;
    logic [16:0] y0, y1;
    pass_t       pl;
    always_comb begin
        pl = pass_reg[QB];
        y0 = qsat(q0_reg[QB], pl.neg0, pl.ovf0);
        y1 = qsat(q1_reg[QB], pl.neg1, pl.ovf1);
        result_next.is_equal = pl.eq;
        if (!pl.is_div) begin
            result_next.r_first    = pl.r0;
            result_next.r_second   = pl.r1;
            result_next.error_flag = pl.err;
        end else if (pl.zero) begin
            result_next.r_first    = '0;
            result_next.r_second   = '0;
            result_next.error_flag = 1'b1;
        end else begin
            result_next.r_first    = y0[15:0];
            result_next.r_second   = y1[15:0];
            result_next.error_flag = y0[16] || y1[16];
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= dv_reg[QB];
        end
    end

    always_ff @(posedge clk) begin
        result_reg <= result_next;
    end

endmodule
